[hw/rtl/plpfm_pkg.sv]
// Package for the pinned LRU page frame manager: sizes, request codes,
// status and fill codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package plpfm_pkg;

   localparam int FRAME_COUNT = 32;
   localparam int PIN_BITS    = 8;
   localparam int FIDX_W      = $clog2(FRAME_COUNT);
   localparam int AGE_W       = $clog2(FRAME_COUNT);
   localparam int SEL_W       = 6;
   localparam logic [SEL_W-1:0] META_SEL = SEL_W'(32);
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   typedef enum logic [2:0] {
      REQ_GET      = 3'd0,
      REQ_ALLOCATE = 3'd1,
      REQ_ENSURE   = 3'd2,
      REQ_UNPIN    = 3'd3,
      REQ_DIRTY    = 3'd4,
      REQ_FLUSH    = 3'd5,
      REQ_DROP     = 3'd6,
      REQ_NONE     = 3'd7
   } req_type_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_NOFRAME = 2'd2;

   localparam logic [1:0] FILL_NONE = 2'd0;
   localparam logic [1:0] FILL_READ = 2'd1;
   localparam logic [1:0] FILL_ZERO = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FLUSH,
      S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture the request
      logic exec;   // perform a single-result request, load output
      logic flush;  // emit one flush result, load output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_flush;
      logic flush_done; // output just loaded was the last flush result
   } stat_type;

endpackage

[hw/rtl/plpfm_datapath.sv]
// Datapath of the page frame manager: frame table, tag compare, victim search,
// recency update, flush scan and the result register. Uses plpfm_pkg.
`timescale 1ns / 1ps

module plpfm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  plpfm_pkg::cmd_type            cmd,
   output plpfm_pkg::stat_type           stat,
   input  logic                          csr_we,
   input  logic [31:0]                   csr_wdata,
   input  logic [2:0]                    req_type,
   input  logic [31:0]                   req_page_id,
   input  logic [5:0]                    req_frame_sel,
   output logic [1:0]                    rsp_status,
   output logic [5:0]                    rsp_frame_out,
   output logic                          rsp_hit,
   output logic                          rsp_writeback,
   output logic [31:0]                   rsp_writeback_page,
   output logic [1:0]                    rsp_fill,
   output logic [31:0]                   rsp_result_page,
   output logic                          rsp_last
);

   localparam int N  = plpfm_pkg::FRAME_COUNT;
   localparam int FW = plpfm_pkg::FIDX_W;
   localparam int AW = plpfm_pkg::AGE_W;
   localparam int PB = plpfm_pkg::PIN_BITS;

   logic [31:0]   tag_ff [N];
   logic [N-1:0]  valid_ff, valid_in;
   logic [N-1:0]  dirty_ff, dirty_in;
   logic [PB-1:0] pins_ff [N];
   logic [PB-1:0] pins_in [N];
   logic [AW-1:0] age_ff  [N];
   logic [AW-1:0] age_in  [N];
   logic [31:0]   count_ff, count_in;
   logic          mdirty_ff, mdirty_in;
   logic [PB-1:0] mpins_ff, mpins_in;

   logic [2:0]  rtype_ff;
   logic [31:0] rid_ff;
   logic [5:0]  rsel_ff;

   logic [1:0]  o_status_ff, o_status_in;
   logic [5:0]  o_frame_ff, o_frame_in;
   logic        o_hit_ff, o_hit_in, o_wb_ff, o_wb_in, o_last_ff, o_last_in;
   logic [31:0] o_wbp_ff, o_wbp_in, o_rp_ff, o_rp_in;
   logic [1:0]  o_fill_ff, o_fill_in;

   logic          tag_we;
   logic [FW-1:0] tag_wa;
   logic [31:0]   tag_wd;

   // per-frame compare and candidate, then priority / max-age selection
   logic [N-1:0]  match;
   logic [N-1:0]  flushable;
   logic          any_match, any_invalid, any_victim, any_flush;
   logic [FW-1:0] match_idx, inv_idx, lru_idx, flush_idx, vic_idx;
   logic [31:0]   eff_id;

   // victim tree: node k keeps the older of children 2k and 2k+1, lower index on a tie
   logic          tree_v [1:2*N-1];
   logic [FW-1:0] tree_i [1:2*N-1];
   logic [AW-1:0] tree_a [1:2*N-1];

   always_comb begin
      eff_id = (rtype_ff == plpfm_pkg::REQ_ALLOCATE) ? count_ff : rid_ff;
      any_match = 1'b0; match_idx = '0;
      any_invalid = 1'b0; inv_idx = '0;
      any_flush = 1'b0; flush_idx = '0;
      for (int i = 0; i < N; i++) begin
         match[i]     = valid_ff[i] && (tag_ff[i] == eff_id);
         flushable[i] = valid_ff[i] && dirty_ff[i];
      end
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i]) begin
            any_match = 1'b1; match_idx = FW'(i);
         end
         if (!valid_ff[i]) begin
            any_invalid = 1'b1; inv_idx = FW'(i);
         end
         if (flushable[i]) begin
            any_flush = 1'b1; flush_idx = FW'(i);
         end
      end
      for (int i = 0; i < N; i++) begin
         tree_v[N+i] = valid_ff[i] && (pins_ff[i] == '0);
         tree_i[N+i] = FW'(i);
         tree_a[N+i] = age_ff[i];
      end
      for (int k = N - 1; k >= 1; k--) begin
         if (tree_v[2*k+1] && (!tree_v[2*k] || tree_a[2*k+1] > tree_a[2*k])) begin
            tree_v[k] = 1'b1; tree_i[k] = tree_i[2*k+1]; tree_a[k] = tree_a[2*k+1];
         end else begin
            tree_v[k] = tree_v[2*k]; tree_i[k] = tree_i[2*k]; tree_a[k] = tree_a[2*k];
         end
      end
      any_victim = tree_v[1];
      lru_idx = tree_i[1];
      vic_idx = any_invalid ? inv_idx : lru_idx;
   end

   function automatic logic [PB-1:0] pin_inc(input logic [PB-1:0] p);
      pin_inc = (p == plpfm_pkg::PIN_MAX) ? p : p + PB'(1);
   endfunction

   always_comb begin
      logic          fresh, refused, do_acq, tch;
      logic [FW-1:0] f;
      logic [AW:0]   old_age;
      fresh = 1'b0; refused = 1'b0; do_acq = 1'b0; tch = 1'b0;
      f = '0; old_age = '0;
      valid_in = valid_ff; dirty_in = dirty_ff;
      pins_in = pins_ff; age_in = age_ff;
      count_in = count_ff; mdirty_in = mdirty_ff; mpins_in = mpins_ff;
      tag_we = 1'b0; tag_wa = vic_idx; tag_wd = eff_id;
      o_status_in = o_status_ff; o_frame_in = o_frame_ff; o_hit_in = o_hit_ff;
      o_wb_in = o_wb_ff; o_wbp_in = o_wbp_ff; o_fill_in = o_fill_ff;
      o_rp_in = o_rp_ff; o_last_in = o_last_ff;

      if (cmd.exec) begin
         o_status_in = plpfm_pkg::ST_OK; o_frame_in = '0; o_hit_in = 1'b0;
         o_wb_in = 1'b0; o_wbp_in = '0; o_fill_in = plpfm_pkg::FILL_NONE;
         o_rp_in = '0; o_last_in = 1'b1;
         unique case (rtype_ff)
            plpfm_pkg::REQ_GET: begin
               refused = (rid_ff == '1) || (rid_ff >= count_ff);
               do_acq = !refused;
            end
            plpfm_pkg::REQ_ALLOCATE: begin
               refused = (count_ff == '1);
               do_acq = !refused;
            end
            plpfm_pkg::REQ_ENSURE: begin
               refused = (rid_ff == '1);
               fresh = !refused && (rid_ff >= count_ff);
               do_acq = !refused;
               if (fresh) begin
                  count_in = rid_ff + 32'd1; mdirty_in = 1'b1;
               end
            end
            plpfm_pkg::REQ_UNPIN: begin
               o_frame_in = rsel_ff;
               if (rsel_ff == plpfm_pkg::META_SEL) begin
                  if (mpins_ff != '0) mpins_in = mpins_ff - PB'(1);
               end else if (rsel_ff < 6'(N) && valid_ff[rsel_ff[FW-1:0]]
                            && pins_ff[rsel_ff[FW-1:0]] != '0) begin
                  pins_in[rsel_ff[FW-1:0]] = pins_ff[rsel_ff[FW-1:0]] - PB'(1);
               end
            end
            plpfm_pkg::REQ_DIRTY: begin
               o_frame_in = rsel_ff;
               if (rsel_ff == plpfm_pkg::META_SEL) mdirty_in = 1'b1;
               else if (rsel_ff < 6'(N) && valid_ff[rsel_ff[FW-1:0]])
                  dirty_in[rsel_ff[FW-1:0]] = 1'b1;
            end
            plpfm_pkg::REQ_DROP: begin
               valid_in = '0; dirty_in = '0;
               for (int i = 0; i < N; i++) begin
                  pins_in[i] = '0; age_in[i] = '0;
               end
            end
            default: ;
         endcase
         if (refused) o_status_in = plpfm_pkg::ST_REFUSED;
         if (do_acq) begin
            if (eff_id == '0) begin
               mpins_in = pin_inc(mpins_ff);
               o_frame_in = plpfm_pkg::META_SEL; o_hit_in = 1'b1;
               if (rtype_ff == plpfm_pkg::REQ_ALLOCATE) begin
                  count_in = count_ff + 32'd1; mdirty_in = 1'b1;
               end
               if (rtype_ff == plpfm_pkg::REQ_ENSURE && fresh) mdirty_in = 1'b1;
               if (rtype_ff != plpfm_pkg::REQ_GET) o_rp_in = eff_id;
               o_fill_in = fresh ? plpfm_pkg::FILL_ZERO : plpfm_pkg::FILL_NONE;
            end else if (any_match || any_invalid || any_victim) begin
               if (any_match) begin
                  f = match_idx; old_age = {1'b0, age_ff[match_idx]};
                  pins_in[f] = pin_inc(pins_ff[f]);
                  o_hit_in = 1'b1;
               end else begin
                  f = vic_idx;
                  old_age = valid_ff[f] ? {1'b0, age_ff[f]} : (AW+1)'(N);
                  if (valid_ff[f] && dirty_ff[f]) begin
                     o_wb_in = 1'b1; o_wbp_in = tag_ff[f];
                  end
                  tag_we = 1'b1; valid_in[f] = 1'b1; dirty_in[f] = 1'b0;
                  pins_in[f] = PB'(1);
               end
               tch = 1'b1;
               o_frame_in = 6'(f);
               if (rtype_ff == plpfm_pkg::REQ_ALLOCATE) begin
                  count_in = count_ff + 32'd1; mdirty_in = 1'b1;
                  dirty_in[f] = 1'b1; o_rp_in = eff_id;
                  o_fill_in = any_match ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_ZERO;
               end else if (rtype_ff == plpfm_pkg::REQ_ENSURE) begin
                  o_rp_in = eff_id;
                  if (fresh) dirty_in[f] = 1'b1;
                  o_fill_in = fresh ? plpfm_pkg::FILL_ZERO :
                              (any_match ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_READ);
               end else begin
                  o_fill_in = any_match ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_READ;
               end
            end else begin
               o_status_in = plpfm_pkg::ST_NOFRAME;
            end
         end
         if (tch) begin
            for (int i = 0; i < N; i++)
               if (FW'(i) != f && valid_ff[i] && {1'b0, age_ff[i]} < old_age)
                  age_in[i] = age_ff[i] + AW'(1);
            age_in[f] = '0;
         end
      end

      if (cmd.flush) begin
         o_status_in = plpfm_pkg::ST_OK; o_hit_in = 1'b0; o_fill_in = plpfm_pkg::FILL_NONE;
         o_rp_in = '0;
         if (any_flush) begin
            dirty_in[flush_idx] = 1'b0;
            o_frame_in = 6'(flush_idx); o_wb_in = 1'b1; o_wbp_in = tag_ff[flush_idx];
            // last when no other frame and no metadata stays dirty
            o_last_in = !mdirty_ff && ((flushable & ~(N'(1) << flush_idx)) == '0);
         end else if (mdirty_ff) begin
            mdirty_in = 1'b0;
            o_frame_in = plpfm_pkg::META_SEL; o_wb_in = 1'b1; o_wbp_in = '0;
            o_last_in = 1'b1;
         end else begin
            o_frame_in = '0; o_wb_in = 1'b0; o_wbp_in = '0; o_last_in = 1'b1;
         end
      end

      if (csr_we) count_in = csr_wdata;
   end

   assign stat.is_flush   = (rtype_ff == plpfm_pkg::REQ_FLUSH);
   assign stat.flush_done = o_last_ff;

   always_ff @(posedge clock) begin
      if (tag_we) tag_ff[tag_wa] <= tag_wd;
      if (cmd.load) begin
         rtype_ff <= req_type; rid_ff <= req_page_id; rsel_ff <= req_frame_sel;
      end
      o_status_ff <= o_status_in; o_frame_ff <= o_frame_in; o_hit_ff <= o_hit_in;
      o_wb_ff <= o_wb_in; o_wbp_ff <= o_wbp_in; o_fill_ff <= o_fill_in;
      o_rp_ff <= o_rp_in; o_last_ff <= o_last_in;
      if (reset) begin
         valid_ff <= '0; dirty_ff <= '0; count_ff <= 32'd2;
         mdirty_ff <= 1'b0; mpins_ff <= '0;
         for (int i = 0; i < N; i++) begin
            pins_ff[i] <= '0; age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in; dirty_ff <= dirty_in; count_ff <= count_in;
         mdirty_ff <= mdirty_in; mpins_ff <= mpins_in;
         pins_ff <= pins_in; age_ff <= age_in;
      end
   end

   assign rsp_status = o_status_ff;
   assign rsp_frame_out = o_frame_ff;
   assign rsp_hit = o_hit_ff;
   assign rsp_writeback = o_wb_ff;
   assign rsp_writeback_page = o_wbp_ff;
   assign rsp_fill = o_fill_ff;
   assign rsp_result_page = o_rp_ff;
   assign rsp_last = o_last_ff;

endmodule

[hw/rtl/plpfm_ctrl.sv]
// Controller of the page frame manager: request sequencing and result handshake.
// Uses plpfm_pkg.
`timescale 1ns / 1ps

module plpfm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  plpfm_pkg::stat_type stat,
   output plpfm_pkg::cmd_type  cmd
);

   plpfm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= plpfm_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         plpfm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = plpfm_pkg::S_EXEC;
            end
         end
         plpfm_pkg::S_EXEC: begin
            // flush results are produced one at a time from the scan
            if (stat.is_flush) cmd.flush = 1'b1;
            else               cmd.exec  = 1'b1;
            state_in = plpfm_pkg::S_OUT;
         end
         plpfm_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.is_flush && !stat.flush_done) state_in = plpfm_pkg::S_FLUSH;
               else                                   state_in = plpfm_pkg::S_IDLE;
            end
         end
         plpfm_pkg::S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in = plpfm_pkg::S_OUT;
         end
         default: state_in = plpfm_pkg::S_IDLE;
      endcase
   end

endmodule

[hw/rtl/pinned_lru_page_frame_manager.sv]
// Top level of the pinned LRU page frame manager: controller plus datapath.
// Depends on plpfm_pkg, plpfm_ctrl and plpfm_datapath.
//
// Usage: a request enters on req_valid/req_stall with req_type, req_page_id
// and req_frame_sel; an item is taken when req_valid is high and req_stall low.
// Results leave on rsp_valid/rsp_stall, one item per handshake; rsp_last marks
// the final result of a request. Flush gives one result per dirty page (frames
// in index order, then the metadata page), or one if none is dirty; every other
// request gives one. Sequence: the request is captured in S_IDLE, executed in
// S_EXEC into the result register, and shown in S_OUT until taken; flush passes
// through S_FLUSH before each extra result. The execute step does the 32-way
// tag compare, victim search and recency update.
// One request is in progress at a time; req_stall is high until its last
// result is taken. While rsp_stall is high the result register holds.
// Reset clears valid, dirty, pin and recency state, page count to 2.
// A csr_we write loads the page count; write only while idle.
`timescale 1ns / 1ps

module pinned_lru_page_frame_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_page_id,
   input  logic [5:0]  req_frame_sel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_frame_out,
   output logic        rsp_hit,
   output logic        rsp_writeback,
   output logic [31:0] rsp_writeback_page,
   output logic [1:0]  rsp_fill,
   output logic [31:0] rsp_result_page,
   output logic        rsp_last
);

   plpfm_pkg::cmd_type  cmd;
   plpfm_pkg::stat_type stat;

   // sequence request, execute and result hand-off
   plpfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold frame table and result register
   plpfm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_page_id        (req_page_id),
      .req_frame_sel      (req_frame_sel),
      .rsp_status         (rsp_status),
      .rsp_frame_out      (rsp_frame_out),
      .rsp_hit            (rsp_hit),
      .rsp_writeback      (rsp_writeback),
      .rsp_writeback_page (rsp_writeback_page),
      .rsp_fill           (rsp_fill),
      .rsp_result_page    (rsp_result_page),
      .rsp_last           (rsp_last)
   );

endmodule

[tb/testbench.sv]
// Self-checking testbench for pinned_lru_page_frame_manager: a directed table,
// then random request phases checked against an in-bench frame table model.
// Depends on plpfm_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [1:0]  status;
      logic [5:0]  frame;
      logic        hit;
      logic        wb;
      logic [31:0] wb_page;
      logic [1:0]  fill;
      logic [31:0] result_page;
      logic        last;
   } answer_type;

   // one row of the directed table; typed rows carry a hand-written answer
   typedef struct {
      plpfm_pkg::req_type_type kind;
      logic [31:0]             page;
      logic [5:0]              sel;
      bit                      typed;
      answer_type              answer;
   } row_type;

   localparam int FRAMES = plpfm_pkg::FRAME_COUNT;
   localparam int PINW   = plpfm_pkg::PIN_BITS;
   localparam logic [31:0] NO_PAGE = 32'hFFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic [31:0] req_page_id = '0;
   logic [5:0]  req_frame_sel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_frame_out;
   logic        rsp_hit;
   logic        rsp_writeback;
   logic [31:0] rsp_writeback_page;
   logic [1:0]  rsp_fill;
   logic [31:0] rsp_result_page;
   logic        rsp_last;

   pinned_lru_page_frame_manager dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // frame table model
   logic [31:0]     frame_page [FRAMES];
   bit              frame_used [FRAMES];
   bit              frame_dirty [FRAMES];
   logic [PINW-1:0] frame_pins [FRAMES];
   int              frame_age [FRAMES];
   logic [31:0]     page_total;
   bit              meta_dirty;
   logic [PINW-1:0] meta_pins;

   answer_type awaited_answers[$];
   int         error_count = 0;
   bit         quiet = 1'b0;     // no idling on either side
   bit         hold_off = 1'b0;  // ask the receiver for one long stall
   bit         override_pending = 1'b0;  // next taken item gets a typed answer
   answer_type override_answer;

   task automatic report(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, what);
   endtask

   function automatic answer_type mk(input logic [1:0] st, input logic [5:0] fr,
                                     input logic h, input logic wb, input logic [31:0] wbp,
                                     input logic [1:0] fl, input logic [31:0] rp,
                                     input logic lst);
      answer_type a;
      a.status = st; a.frame = fr; a.hit = h; a.wb = wb; a.wb_page = wbp;
      a.fill = fl; a.result_page = rp; a.last = lst;
      return a;
   endfunction

   function automatic logic [PINW-1:0] pin_up(input logic [PINW-1:0] p);
      return (p == plpfm_pkg::PIN_MAX) ? p : p + 1'b1;
   endfunction

   // make frame f the most recent; prior_age is FRAMES for a new frame
   function automatic void make_recent(input int f, input int prior_age);
      for (int i = 0; i < FRAMES; i++)
         if (i != f && frame_used[i] && frame_age[i] < prior_age) frame_age[i]++;
      frame_age[f] = 0;
   endfunction

   function automatic bit pin_page(input logic [31:0] id, output logic [5:0] fr,
                                   output logic h, output logic wb, output logic [31:0] wbp);
      int victim = -1;
      int prior_age = FRAMES;
      wb = 1'b0; wbp = '0; fr = '0; h = 1'b0;
      if (id == 0) begin
         meta_pins = pin_up(meta_pins);
         fr = plpfm_pkg::META_SEL; h = 1'b1;
         return 1'b1;
      end
      for (int i = 0; i < FRAMES; i++) begin
         if (frame_used[i] && frame_page[i] == id) begin
            make_recent(i, frame_age[i]);
            frame_pins[i] = pin_up(frame_pins[i]);
            fr = 6'(i); h = 1'b1;
            return 1'b1;
         end
      end
      for (int i = 0; i < FRAMES; i++) begin
         if (!frame_used[i]) begin
            victim = i;
            break;
         end
         if (frame_pins[i] != 0) continue;
         if (victim < 0 || frame_age[i] > frame_age[victim]) victim = i;
      end
      if (victim < 0) return 1'b0;
      if (frame_used[victim]) begin
         prior_age = frame_age[victim];
         if (frame_dirty[victim]) begin
            wb = 1'b1; wbp = frame_page[victim];
         end
      end
      frame_page[victim] = id;
      frame_used[victim] = 1'b1;
      frame_dirty[victim] = 1'b0;
      frame_pins[victim] = 1;
      make_recent(victim, prior_age);
      fr = 6'(victim);
      return 1'b1;
   endfunction

   function automatic void mark_dirty(input logic [5:0] sel);
      if (sel == plpfm_pkg::META_SEL) meta_dirty = 1'b1;
      else if (sel < FRAMES && frame_used[sel]) frame_dirty[sel] = 1'b1;
   endfunction

   // advance the model by one request and queue the answers it gives
   function automatic void predict_answers(input logic [2:0] kind, input logic [31:0] id,
                                           input logic [5:0] sel);
      logic [5:0]  fr;
      logic        h, wb, fresh;
      logic [31:0] wbp, pg;
      int          total, n;
      answer_type  refused, noframe;
      refused = mk(plpfm_pkg::ST_REFUSED, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1);
      noframe = mk(plpfm_pkg::ST_NOFRAME, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1);
      case (plpfm_pkg::req_type_type'(kind))
         plpfm_pkg::REQ_GET: begin
            if (id == NO_PAGE || id >= page_total) awaited_answers.push_back(refused);
            else if (!pin_page(id, fr, h, wb, wbp)) awaited_answers.push_back(noframe);
            else awaited_answers.push_back(mk(plpfm_pkg::ST_OK, fr, h, wb, wbp,
                     h ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_READ, 0, 1));
         end
         plpfm_pkg::REQ_ALLOCATE: begin
            pg = page_total;
            if (pg == NO_PAGE) awaited_answers.push_back(refused);
            else if (!pin_page(pg, fr, h, wb, wbp)) awaited_answers.push_back(noframe);
            else begin
               page_total++;
               meta_dirty = 1'b1;
               mark_dirty(fr);
               awaited_answers.push_back(mk(plpfm_pkg::ST_OK, fr, h, wb, wbp,
                  h ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_ZERO, pg, 1));
            end
         end
         plpfm_pkg::REQ_ENSURE: begin
            if (id == NO_PAGE) awaited_answers.push_back(refused);
            else begin
               fresh = id >= page_total;
               if (fresh) begin
                  page_total = id + 1;
                  meta_dirty = 1'b1;
               end
               if (!pin_page(id, fr, h, wb, wbp)) awaited_answers.push_back(noframe);
               else begin
                  if (fresh) mark_dirty(fr);
                  awaited_answers.push_back(mk(plpfm_pkg::ST_OK, fr, h, wb, wbp,
                     fresh ? plpfm_pkg::FILL_ZERO :
                     (h ? plpfm_pkg::FILL_NONE : plpfm_pkg::FILL_READ), id, 1));
               end
            end
         end
         plpfm_pkg::REQ_UNPIN: begin
            if (sel == plpfm_pkg::META_SEL) begin
               if (meta_pins != 0) meta_pins--;
            end else if (sel < FRAMES && frame_used[sel] && frame_pins[sel] != 0) begin
               frame_pins[sel]--;
            end
            awaited_answers.push_back(mk(plpfm_pkg::ST_OK, sel, 0, 0, 0,
                                         plpfm_pkg::FILL_NONE, 0, 1));
         end
         plpfm_pkg::REQ_DIRTY: begin
            mark_dirty(sel);
            awaited_answers.push_back(mk(plpfm_pkg::ST_OK, sel, 0, 0, 0,
                                         plpfm_pkg::FILL_NONE, 0, 1));
         end
         plpfm_pkg::REQ_FLUSH: begin
            total = meta_dirty ? 1 : 0;
            n = 0;
            for (int i = 0; i < FRAMES; i++)
               if (frame_used[i] && frame_dirty[i]) total++;
            if (total == 0)
               awaited_answers.push_back(mk(plpfm_pkg::ST_OK, 0, 0, 0, 0,
                                            plpfm_pkg::FILL_NONE, 0, 1));
            for (int i = 0; i < FRAMES; i++) begin
               if (frame_used[i] && frame_dirty[i]) begin
                  frame_dirty[i] = 1'b0;
                  n++;
                  awaited_answers.push_back(mk(plpfm_pkg::ST_OK, 6'(i), 0, 1, frame_page[i],
                                               plpfm_pkg::FILL_NONE, 0, n == total));
               end
            end
            if (meta_dirty) begin
               meta_dirty = 1'b0;
               awaited_answers.push_back(mk(plpfm_pkg::ST_OK, plpfm_pkg::META_SEL, 0, 1, 0,
                                            plpfm_pkg::FILL_NONE, 0, 1));
            end
         end
         plpfm_pkg::REQ_DROP: begin
            for (int i = 0; i < FRAMES; i++) begin
               frame_used[i] = 1'b0; frame_dirty[i] = 1'b0;
               frame_pins[i] = 0; frame_age[i] = 0;
            end
            awaited_answers.push_back(mk(plpfm_pkg::ST_OK, 0, 0, 0, 0,
                                         plpfm_pkg::FILL_NONE, 0, 1));
         end
         default: awaited_answers.push_back(mk(plpfm_pkg::ST_OK, 0, 0, 0, 0,
                                               plpfm_pkg::FILL_NONE, 0, 1));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // sample both handshakes at the rising edge: check results, model accepted items
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report("result with nothing awaited");
            end else begin
               want = awaited_answers.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("frame_out", 32'(rsp_frame_out), 32'(want.frame));
               check_field("hit", 32'(rsp_hit), 32'(want.hit));
               check_field("writeback", 32'(rsp_writeback), 32'(want.wb));
               check_field("writeback_page", rsp_writeback_page, want.wb_page);
               check_field("fill", 32'(rsp_fill), 32'(want.fill));
               check_field("result_page", rsp_result_page, want.result_page);
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_answers(req_type, req_page_id, req_frame_sel);
            // swap the model's answer for the typed one, the model state still advances
            if (override_pending) begin
               void'(awaited_answers.pop_back());
               awaited_answers.push_back(override_answer);
               override_pending = 1'b0;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request, none when quiet
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (80) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
      end
   end

   // offer one item, maybe after an idle burst, and hold it until taken
   task automatic send_item(input logic [2:0] kind, input logic [31:0] id,
                            input logic [5:0] sel);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_page_id <= id;
      req_frame_sel <= sel;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every awaited result has come back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (awaited_answers.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_page_count(input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      page_total = value;
   endtask

   function automatic logic [5:0] pick_sel;
      int f = $urandom_range(0, FRAMES - 1);
      case ($urandom_range(0, 9))
         0: return plpfm_pkg::META_SEL;
         1: return 6'($urandom_range(0, 63));
         default: begin
            for (int i = 0; i < FRAMES; i++)
               if (frame_used[(f + i) % FRAMES] && frame_pins[(f + i) % FRAMES] != 0)
                  return 6'((f + i) % FRAMES);
            return 6'(f);
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_page;
      int f = $urandom_range(0, FRAMES - 1);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return NO_PAGE;
         2, 3: return $urandom_range(0, 70);
         4: return page_total + $urandom_range(0, 3);
         default: return frame_used[f] ? frame_page[f] : $urandom_range(0, 40);
      endcase
   endfunction

   task automatic random_item;
      int pick = $urandom_range(0, 99);
      if (pick < 35)
         send_item(plpfm_pkg::REQ_GET, pick_page(), 6'($urandom_range(0, 63)));
      else if (pick < 44)
         send_item(plpfm_pkg::REQ_ALLOCATE, $urandom, 6'($urandom_range(0, 63)));
      else if (pick < 56)
         send_item(plpfm_pkg::REQ_ENSURE, pick_page(), 6'($urandom_range(0, 63)));
      else if (pick < 82) send_item(plpfm_pkg::REQ_UNPIN, $urandom, pick_sel());
      else if (pick < 90) send_item(plpfm_pkg::REQ_DIRTY, $urandom, pick_sel());
      else if (pick < 95)
         send_item(plpfm_pkg::REQ_FLUSH, $urandom, 6'($urandom_range(0, 63)));
      else if (pick < 97)
         send_item(plpfm_pkg::REQ_DROP, $urandom, 6'($urandom_range(0, 63)));
      else send_item(plpfm_pkg::REQ_NONE, $urandom, 6'($urandom_range(0, 63)));
   endtask

   initial begin
      row_type     rows[$];
      logic [31:0] phase_count[5];
      answer_type  zero_ok;
      zero_ok = mk(plpfm_pkg::ST_OK, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1);
      phase_count = '{32'd48, 32'd2, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 32'd100};

      for (int i = 0; i < FRAMES; i++) begin
         frame_page[i] = '0; frame_used[i] = 0; frame_dirty[i] = 0;
         frame_pins[i] = 0; frame_age[i] = 0;
      end
      page_total = 2;
      meta_dirty = 0;
      meta_pins = 0;

      // directed table: typed rows hold a hand-written answer
      rows = '{
         '{plpfm_pkg::REQ_GET, 32'd0, 6'd0, 1,
           mk(plpfm_pkg::ST_OK, plpfm_pkg::META_SEL, 1, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_GET, 32'd1, 6'd0, 1,
           mk(plpfm_pkg::ST_OK, 0, 0, 0, 0, plpfm_pkg::FILL_READ, 0, 1)},
         '{plpfm_pkg::REQ_GET, 32'd2, 6'd0, 1,
           mk(plpfm_pkg::ST_REFUSED, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_GET, NO_PAGE, 6'd63, 1,
           mk(plpfm_pkg::ST_REFUSED, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_ENSURE, NO_PAGE, 6'd0, 1,
           mk(plpfm_pkg::ST_REFUSED, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_ALLOCATE, 32'd0, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_ENSURE, 32'd10, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_ENSURE, 32'd1, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_ENSURE, 32'd10, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_ENSURE, 32'd0, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_DIRTY, 32'd0, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_DIRTY, 32'd0, 6'd40, 1,
           mk(plpfm_pkg::ST_OK, 6'd40, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, 6'd63, 1,
           mk(plpfm_pkg::ST_OK, 6'd63, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, 6'd31, 1,
           mk(plpfm_pkg::ST_OK, 6'd31, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_FLUSH, 32'd0, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_FLUSH, 32'd0, 6'd0, 1, zero_ok},
         '{plpfm_pkg::REQ_NONE, NO_PAGE, 6'd63, 1, zero_ok},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, plpfm_pkg::META_SEL, 0, zero_ok},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, plpfm_pkg::META_SEL, 0, zero_ok},
         '{plpfm_pkg::REQ_UNPIN, 32'd0, plpfm_pkg::META_SEL, 0, zero_ok},
         '{plpfm_pkg::REQ_ENSURE, 32'hFFFF_FFFE, 6'd0, 0, zero_ok},
         '{plpfm_pkg::REQ_ALLOCATE, 32'd0, 6'd0, 1,
           mk(plpfm_pkg::ST_REFUSED, 0, 0, 0, 0, plpfm_pkg::FILL_NONE, 0, 1)},
         '{plpfm_pkg::REQ_DROP, 32'd0, 6'd0, 1, zero_ok}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      load_page_count(32'd2);

      foreach (rows[r]) begin
         // arm the typed answer only after the previous item has been modeled
         @(negedge clock);
         if (rows[r].typed) begin
            override_answer = rows[r].answer;
            override_pending = 1'b1;
         end
         send_item(rows[r].kind, rows[r].page, rows[r].sel);
      end
      drain();

      // push one frame's pin count to saturation, then step it back down
      load_page_count(32'd16);
      repeat (257) send_item(plpfm_pkg::REQ_GET, 32'd1, 6'd0);
      repeat (3) send_item(plpfm_pkg::REQ_UNPIN, 32'd0, 6'd0);
      send_item(plpfm_pkg::REQ_DROP, 32'd0, 6'd0);
      drain();

      // random phases, one page count each; hold the receiver off in the first
      foreach (phase_count[p]) begin
         load_page_count(phase_count[p]);
         if (p == 0) hold_off = 1'b1;
         if (p == 4) quiet = 1'b1;
         repeat (29) random_item();
         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("pinned_lru_page_frame_manager: match");
      end else begin
         $display("pinned_lru_page_frame_manager: mismatch");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("pinned_lru_page_frame_manager: mismatch");
      $finish;
   end

endmodule
